>>> rtl/slrg_pkg.sv
// shared constants, state encoding and control structs for the shuffled lehmer generator
package slrg_pkg;

	localparam int unsigned DEF_TABLE_ENTRIES = 32;
	localparam int unsigned WARMUP_STEPS = 8;

	localparam logic [14:0] LEHMER_MUL = 15'd16807;
	localparam logic [30:0] LEHMER_MOD = 31'h7FFF_FFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT_MUL,
		ST_INIT_FOLD,
		ST_INIT_WAIT,
		ST_DRAW_READ,
		ST_DRAW_FOLD
	} slrg_state_t;

	typedef struct packed {
		logic load_seed;
		logic start_init;
		logic init_step;
		logic draw_read;
		logic draw_commit;
	} slrg_cmd_t;

	typedef struct packed {
		logic need_init;
		logic init_last;
		logic out_free;
	} slrg_status_t;

endpackage

>>> rtl/shuffled_lehmer_random_generator_unit.sv
// top level of the shuffled minimal-standard lehmer random generator
//
// input channel: item_valid / item_stall with cmd and seed_value. cmd = 1 loads
// seed_value as the generator state and produces no word; cmd = 0 draws one value.
// output channel: result_valid / result_stall with random_value, the numerator of a
// fraction over 2^31-1.
// a load needs only its accept. a draw runs through the accept, a table read and the
// modular fold with the table update, which registers the word. the step is one 32x15
// multiply into a register, then a fold.
// when the state is not positive or the shuffle output is zero, the draw first
// reinitializes: 8 warm-up steps plus one step per table entry, each a multiply state
// and a fold state, then a settle state before the table read.
// reset clears the state and the shuffle output, so the first draw reinitializes.
// the output word sits in a register; a load is still taken while it waits, and a
// draw holds in its final cycle until the waiting word is taken.
module shuffled_lehmer_random_generator_unit
	import slrg_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               cmd,
	input  logic signed [31:0] seed_value,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [30:0]        random_value
);

	slrg_cmd_t ctrl;
	slrg_status_t status;

	slrg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.cmd       (cmd),
		.status    (status),
		.ctrl      (ctrl),
		.item_stall(item_stall)
	);

	slrg_dp #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.status      (status),
		.seed_value  (seed_value),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.random_value(random_value)
	);

endmodule

>>> rtl/slrg_ram.sv
// generic single-write, single-read ram with registered read data
module slrg_ram #(
	parameter int unsigned WIDTH = 31,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/slrg_ctrl.sv
// sequencer for seed loads, table initialization and draws
module slrg_ctrl
	import slrg_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	input  logic         cmd,
	input  slrg_status_t status,
	output slrg_cmd_t    ctrl,
	output logic         item_stall
);

	slrg_state_t state_q;
	slrg_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid && !cmd) begin
					state_d = status.need_init ? ST_INIT_MUL : ST_DRAW_READ;
				end
			end
			ST_INIT_MUL: state_d = ST_INIT_FOLD;
			ST_INIT_FOLD: begin
				state_d = status.init_last ? ST_INIT_WAIT : ST_INIT_MUL;
			end
			// lets the index pipeline catch up with the new shuffle output
			ST_INIT_WAIT: state_d = ST_DRAW_READ;
			ST_DRAW_READ: state_d = ST_DRAW_FOLD;
			ST_DRAW_FOLD: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		item_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				ctrl.load_seed = item_valid && cmd;
				ctrl.start_init = item_valid && !cmd && status.need_init;
			end
			ST_INIT_MUL: ;
			ST_INIT_FOLD: ctrl.init_step = 1'b1;
			ST_INIT_WAIT: ;
			ST_DRAW_READ: ctrl.draw_read = 1'b1;
			ST_DRAW_FOLD: ctrl.draw_commit = status.out_free;
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT_FOLD && status.init_last) |=> state_q == ST_INIT_WAIT)
		else $error("init sequence did not end after the last fill step");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAW_FOLD && !status.out_free) |=> state_q == ST_DRAW_FOLD)
		else $error("draw left its commit state with the output word still held");

	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && !cmd && status.need_init) |=> state_q == ST_INIT_MUL)
		else $error("draw with invalid state skipped initialization");

endmodule

>>> rtl/slrg_dp.sv
// generator state, modular step, shuffle index pipeline, shuffle table and output word
module slrg_dp
	import slrg_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  slrg_cmd_t          ctrl,
	output slrg_status_t       status,
	input  logic signed [31:0] seed_value,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [30:0]        random_value
);

	localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
	localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + WARMUP_STEPS);
	localparam logic [CNT_W-1:0] CNT_START = CNT_W'(TABLE_ENTRIES + WARMUP_STEPS - 1);
	localparam longint BUCKET = 1 + (64'd2147483646 / TABLE_ENTRIES);
	// quotient by the bucket size as a reciprocal multiply, short by at most one
	localparam int unsigned IDX_K = 39;
	localparam longint RECIP = (64'd1 << IDX_K) / BUCKET;
	localparam int unsigned PROD_W = IDX_K + IDX_W + 1;

	logic [31:0] lcg_q;
	logic [30:0] shuf_q;
	logic [30:0] shuf_d;
	logic [CNT_W-1:0] cnt_q;
	logic [46:0] prod_q;
	logic [31:0] fold_sum;
	logic [30:0] fold;
	logic [31:0] lcg_init;

	logic [PROD_W-1:0] idx_prod_s1;
	logic [30:0] shuf_s1;
	logic [IDX_W-1:0] idx_s2;
	logic [IDX_W-1:0] idx_q0;
	logic [IDX_W:0] idx_q0p1;
	logic [31:0] idx_edge;
	logic idx_bump;

	logic ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [30:0] ram_rdata;
	logic res_valid_q;
	logic [30:0] res_q;

	// 2^31 == 1 mod the modulus, so the high part folds onto the low part
	always_ff @(posedge clk) begin
		prod_q <= 47'(lcg_q) * 47'(LEHMER_MUL);
	end

	assign fold_sum = {16'd0, prod_q[46:31]} + {1'b0, prod_q[30:0]};
	assign fold = (fold_sum >= {1'b0, LEHMER_MOD}) ? 31'(fold_sum - {1'b0, LEHMER_MOD})
		: fold_sum[30:0];

	// negative seed is negated, zero or positive restarts from one
	assign lcg_init = lcg_q[31] ? (~lcg_q + 32'd1) : 32'd1;

	always_comb begin
		shuf_d = shuf_q;
		if (ctrl.init_step && cnt_q == '0) begin
			shuf_d = fold;
		end else if (ctrl.draw_commit) begin
			shuf_d = ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_q <= '0;
			shuf_q <= '0;
			cnt_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			shuf_q <= shuf_d;
			if (ctrl.load_seed) begin
				lcg_q <= seed_value;
			end else if (ctrl.start_init) begin
				lcg_q <= lcg_init;
			end else if (ctrl.init_step || ctrl.draw_commit) begin
				lcg_q <= {1'b0, fold};
			end
			if (ctrl.start_init) begin
				cnt_q <= CNT_START;
			end else if (ctrl.init_step && cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (ctrl.draw_commit) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.draw_commit) begin
			res_q <= ram_rdata;
		end
	end

	// index pipeline follows the value the shuffle output is about to take
	always_ff @(posedge clk) begin
		idx_prod_s1 <= PROD_W'(shuf_d) * PROD_W'(RECIP);
		shuf_s1 <= shuf_d;
		idx_s2 <= idx_q0 + IDX_W'(idx_bump);
	end

	assign idx_q0 = idx_prod_s1[IDX_K +: IDX_W];
	assign idx_q0p1 = {1'b0, idx_q0} + (IDX_W + 1)'(1);
	assign idx_edge = 32'(idx_q0p1) * 32'(BUCKET);
	assign idx_bump = {1'b0, shuf_s1} >= idx_edge;

	always_comb begin
		ram_we = ctrl.draw_commit;
		ram_waddr = idx_s2;
		if (ctrl.init_step) begin
			ram_we = cnt_q < CNT_W'(TABLE_ENTRIES);
			ram_waddr = cnt_q[IDX_W-1:0];
		end
	end

	slrg_ram #(
		.WIDTH(31),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(fold),
		.re   (ctrl.draw_read),
		.raddr(idx_s2),
		.rdata(ram_rdata)
	);

	assign status.need_init = lcg_q[31] || lcg_q == '0 || shuf_q == '0;
	assign status.init_last = cnt_q == '0;
	assign status.out_free = !res_valid_q || !result_stall;

	assign result_valid = res_valid_q;
	assign random_value = res_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.draw_commit |=> result_valid)
		else $error("committed draw did not present a word");

	assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.init_step || ctrl.draw_commit) |=> lcg_q < {1'b0, LEHMER_MOD})
		else $error("generator state left the modulus range");

	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.draw_read |-> 32'(idx_s2) < TABLE_ENTRIES)
		else $error("shuffle index beyond table");

endmodule
